/* hdl/aip_pkg.sv */
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types, constants and character helpers for the ASCII integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package aip_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int COUNT_WIDTH = 16;
    localparam int RADIX_WIDTH = 6;
    localparam int DIGIT_WIDTH = 7;
    localparam int WIDE_WIDTH  = VALUE_WIDTH + DIGIT_WIDTH;

    localparam logic [RADIX_WIDTH-1:0] RADIX_AUTO = RADIX_WIDTH'(0);
    localparam logic [RADIX_WIDTH-1:0] RADIX_ONE  = RADIX_WIDTH'(1);
    localparam logic [RADIX_WIDTH-1:0] RADIX_OCT  = RADIX_WIDTH'(8);
    localparam logic [RADIX_WIDTH-1:0] RADIX_DEC  = RADIX_WIDTH'(10);
    localparam logic [RADIX_WIDTH-1:0] RADIX_HEX  = RADIX_WIDTH'(16);
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX  = RADIX_WIDTH'(36);

    localparam logic [DIGIT_WIDTH-1:0] DIGIT_NONE = DIGIT_WIDTH'(64);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } char_word_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic [COUNT_WIDTH-1:0]        end_offset;
        logic                          converted;
        logic                          range_error;
    } num_word_t;

    // Result of one parse step towards the output register
    typedef struct packed {
        logic      emit;
        num_word_t word;
    } aip_result_t;

    function automatic logic [DIGIT_WIDTH-1:0] digit_of(input logic [7:0] c);
        logic [DIGIT_WIDTH-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = DIGIT_WIDTH'(c - CH_ZERO);
        else if (c >= CH_LO_A && c <= CH_LO_Z)
            d = DIGIT_WIDTH'(c - (CH_LO_A - 8'd10));
        else if (c >= CH_UP_A && c <= CH_UP_Z)
            d = DIGIT_WIDTH'(c - (CH_UP_A - 8'd10));
        return d;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_HT && c <= CH_CR);
    endfunction

endpackage

`default_nettype wire

/* hdl/aip_in_stage.sv */
// ----------------------------------------------------------------------------
// aip_in_stage
// Input register: holds one accepted byte until the parse step takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module aip_in_stage
    import aip_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_stall,
    input  wire char_word_t char_data,
    input  wire logic       advance,
    output logic            held_valid,
    output char_word_t      held_word
);

    logic       valid_reg;
    logic       valid_next;
    char_word_t word_reg;

    // Stall only while a held byte cannot move on
    assign char_stall = valid_reg && !advance;
    assign valid_next = char_stall ? valid_reg : char_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            word_reg <= char_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

`default_nettype wire

/* hdl/aip_core.sv */
// ----------------------------------------------------------------------------
// aip_core
// Parse state and the combinational step: whitespace, sign, prefix, digit accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module aip_core
    import aip_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire char_word_t             word,
    input  wire logic [RADIX_WIDTH-1:0] radix,
    output aip_result_t                 result
);

    typedef enum logic [5:0] {
        PH_DONE   = 6'b000001,
        PH_LEAD   = 6'b000010,
        PH_SIGN   = 6'b000100,
        PH_ZERO   = 6'b001000,
        PH_HEXPFX = 6'b010000,
        PH_DIGITS = 6'b100000
    } phase_t;

    phase_t                   phase_reg,  phase_next;
    logic                     neg_reg,    neg_next;
    logic [VALUE_WIDTH-1:0]   acc_reg,    acc_next;
    logic                     ovf_reg,    ovf_next;
    logic                     seen_reg,   seen_next;
    logic [RADIX_WIDTH-1:0]   base_reg,   base_next;
    logic [COUNT_WIDTH:0]     cnt_reg,    cnt_next;

    logic                     bad_radix;
    logic                     sign_path;
    logic                     digit_path;
    logic                     do_acc;
    logic                     emit;
    logic                     step_back;
    logic [DIGIT_WIDTH-1:0]   digit;
    logic [WIDE_WIDTH-1:0]    wide;
    logic [WIDE_WIDTH-1:0]    limit;
    logic [COUNT_WIDTH:0]     end_raw;
    logic signed [VALUE_WIDTH-1:0] value;

    assign digit = digit_of(word.ch);

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        seen_next  = seen_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        bad_radix  = 1'b0;
        sign_path  = 1'b0;
        digit_path = 1'b0;
        do_acc     = 1'b0;
        emit       = 1'b0;
        step_back  = 1'b0;
        wide       = '0;
        limit      = '0;

        // Open a new string: latch radix, clear the accumulation
        if (word.start_req)
        begin
            phase_next = PH_LEAD;
            neg_next   = 1'b0;
            acc_next   = '0;
            ovf_next   = 1'b0;
            seen_next  = 1'b0;
            cnt_next   = '0;
            base_next  = radix;
            if (radix == RADIX_ONE || radix > RADIX_MAX)
            begin
                bad_radix  = 1'b1;
                emit       = 1'b1;
                phase_next = PH_DONE;
            end
        end

        if (!bad_radix && phase_next != PH_DONE)
        begin
            unique case (phase_next)
                PH_LEAD:
                begin
                    if (is_blank(word.ch))
                    begin
                        phase_next = PH_LEAD;
                    end
                    else if (word.ch == CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGN;
                    end
                    else if (word.ch == CH_PLUS)
                    begin
                        phase_next = PH_SIGN;
                    end
                    else
                    begin
                        sign_path = 1'b1;
                    end
                end
                PH_SIGN:
                begin
                    sign_path = 1'b1;
                end
                PH_ZERO:
                begin
                    if (word.ch == CH_LO_X || word.ch == CH_UP_X)
                    begin
                        base_next  = RADIX_HEX;
                        phase_next = PH_HEXPFX;
                    end
                    else
                    begin
                        if (base_next == RADIX_AUTO)
                        begin
                            base_next = RADIX_OCT;
                        end
                        phase_next = PH_DIGITS;
                        digit_path = 1'b1;
                    end
                end
                PH_HEXPFX:
                begin
                    if (digit < DIGIT_WIDTH'(RADIX_HEX))
                    begin
                        do_acc     = 1'b1;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        step_back = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    digit_path = 1'b1;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase

            // First byte after an optional sign
            if (sign_path)
            begin
                if (word.ch == CH_ZERO &&
                    (base_next == RADIX_AUTO || base_next == RADIX_HEX))
                begin
                    seen_next  = 1'b1;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    if (base_next == RADIX_AUTO)
                    begin
                        base_next = RADIX_DEC;
                    end
                    if (digit < DIGIT_WIDTH'(base_next))
                    begin
                        do_acc     = 1'b1;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end

            if (digit_path)
            begin
                if (digit < DIGIT_WIDTH'(base_next))
                begin
                    do_acc = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                end
            end

            // Multiply-add; once past the limit, digits are consumed only
            if (do_acc)
            begin
                seen_next = 1'b1;
                limit = neg_next ? WIDE_WIDTH'($unsigned(VALUE_MIN))
                                 : WIDE_WIDTH'($unsigned(VALUE_MAX));
                wide  = WIDE_WIDTH'(acc_next) * WIDE_WIDTH'(base_next)
                      + WIDE_WIDTH'(digit);
                if (!ovf_next)
                begin
                    if (wide > limit)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = wide[VALUE_WIDTH-1:0];
                    end
                end
            end

            if (emit)
            begin
                phase_next = PH_DONE;
            end

            if (!cnt_next[COUNT_WIDTH])
            begin
                cnt_next = cnt_next + (COUNT_WIDTH+1)'(1);
            end
        end
    end

    // Result fields, from the state before this byte's count advance
    always_comb
    begin
        end_raw = step_back ? cnt_reg - (COUNT_WIDTH+1)'(1) : cnt_reg;
        if (word.start_req)
        begin
            end_raw = '0;
        end
        if (ovf_next)
        begin
            value = neg_next ? VALUE_MIN : VALUE_MAX;
        end
        else
        begin
            value = neg_next ? -$signed(acc_next) : $signed(acc_next);
        end
        result.emit                   = emit;
        result.word.value             = seen_next ? value : '0;
        result.word.end_offset        = !seen_next ? '0 :
                                        end_raw[COUNT_WIDTH] ? '1 :
                                        end_raw[COUNT_WIDTH-1:0];
        result.word.converted         = seen_next;
        result.word.range_error       = seen_next && ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            base_reg  <= '0;
            cnt_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            seen_reg  <= seen_next;
            base_reg  <= base_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/aip_out_stage.sv */
// ----------------------------------------------------------------------------
// aip_out_stage
// Result register: holds a finished number until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module aip_out_stage
    import aip_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire aip_result_t result,
    output logic             room,
    output logic             num_valid,
    input  wire logic        num_stall,
    output num_word_t        num_data
);

    logic      valid_reg;
    logic      valid_next;
    num_word_t word_reg;

    assign room = !valid_reg || !num_stall;

    always_comb
    begin
        valid_next = valid_reg && num_stall;
        if (advance && result.emit)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            word_reg <= result.word;
        end
    end

    assign num_valid = valid_reg;
    assign num_data  = word_reg;

endmodule

`default_nettype wire

/* hdl/ascii_integer_parser.sv */
// Flow: a taken byte waits in the input register; the parse step then loads its
//   number, if any, into the result register, so num_valid rises with that load.
// Throughput: one byte per cycle; bytes stall only while a held byte meets a
//   full result register under num_stall.
// Reset (rst_n low, asynchronous): both stage registers empty, parser waiting
//   for a start byte, radix 0 (auto-detect).
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streaming string-to-long conversion over a byte stream with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_integer_parser
    import aip_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   radix_we,
    input  wire logic [RADIX_WIDTH-1:0] radix_wdata,
    input  wire logic                   char_valid,
    output logic                        char_stall,
    input  wire char_word_t             char_data,
    output logic                        num_valid,
    input  wire logic                   num_stall,
    output num_word_t                   num_data
);

    logic [RADIX_WIDTH-1:0] radix_reg;
    logic [RADIX_WIDTH-1:0] radix_next;
    logic                   held_valid;
    char_word_t             held_word;
    logic                   room;
    logic                   advance;
    aip_result_t            result;

    // Radix register; only read when a start byte is parsed
    assign radix_next = radix_we ? radix_wdata : radix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= '0;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // Advance the held byte whenever the result register can take a word,
    // so a number leaves in the same cycle as the next one arrives
    assign advance = held_valid && room;

    aip_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .advance    (advance),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    // Parse step: whitespace, sign, 0x prefix, base pick, digit accumulate
    aip_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .word    (held_word),
        .radix   (radix_reg),
        .result  (result)
    );

    // Hold the finished number until the consumer drops its stall
    aip_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .result    (result),
        .room      (room),
        .num_valid (num_valid),
        .num_stall (num_stall),
        .num_data  (num_data)
    );

endmodule

`default_nettype wire

/* hdl/aip_checker.sv */
// ----------------------------------------------------------------------------
// aip_checker
// Port-level checks on the ASCII integer parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aip_checker
    import aip_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      char_stall,
    input  wire logic      num_valid,
    input  wire logic      num_stall,
    input  wire num_word_t num_data
);

    // A held result word stays put while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        num_valid && num_stall |=> num_valid && $stable(num_data))
        else $error("result word changed under stall");

    // Input only backs up when the result side is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> num_valid && num_stall)
        else $error("input stalled with free result register");

    // No conversion gives an all-zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        num_valid && !num_data.converted |->
            num_data.value == '0 && num_data.end_offset == '0 && !num_data.range_error)
        else $error("non-conversion carries data");

    // A range error always reports a saturated limit
    assert property (@(posedge clk) disable iff (!rst_n)
        num_valid && num_data.range_error |->
            num_data.value == VALUE_MAX || num_data.value == VALUE_MIN)
        else $error("range error without saturated value");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_stall (char_stall),
    .num_valid  (num_valid),
    .num_stall  (num_stall),
    .num_data   (num_data)
);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming ASCII-to-integer parser. A stimulus
// table covers reset defaults, prefix and radix corner cases and saturation.
// Random strings with random radix, idling and a long output hold-off follow.
// Every accepted byte is run through a local parser model and each number
// word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module tb;

    import aip_pkg::*;

    localparam int          CLK_PERIOD  = 8;
    localparam int          RESET_TICKS = 12;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          REPORT_MAX  = 10;
    localparam int          HOLD_TICKS  = 300;
    localparam int          DRAIN_TICKS = 4;
    localparam int          LONG_RUN    = 40;
    localparam int unsigned COUNT_MAX   = (1 << COUNT_WIDTH) - 1;

    localparam logic [RADIX_WIDTH-1:0] RADIX_BIN = RADIX_WIDTH'(2);
    localparam logic [RADIX_WIDTH-1:0] RADIX_TOP = RADIX_WIDTH'(63);
    localparam logic [RADIX_WIDTH-1:0] RADIX_37  = RADIX_WIDTH'(37);

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_ONES = 8'hFF;
    localparam logic [7:0] CH_LO_G = 8'h67;
    localparam logic [7:0] CH_LO_Q = 8'h71;
    localparam logic [7:0] CH_SEVN = 8'h37;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_THRE = 8'h33;

    // Parser phases as tracked by the local model
    typedef enum logic [2:0] {
        SCAN_DONE,
        SCAN_LEAD,
        SCAN_SIGN,
        SCAN_ZERO,
        SCAN_HEXPFX,
        SCAN_DIGITS
    } scan_phase_t;

    // One line of the stimulus table: a radix write or a byte, optionally
    // with a number word typed in by hand
    typedef struct packed {
        logic                   is_cfg;
        logic [RADIX_WIDTH-1:0] radix;
        char_word_t             word;
        logic                   pinned;
        num_word_t              want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   radix_we;
    logic [RADIX_WIDTH-1:0] radix_wdata;
    logic                   char_valid;
    logic                   char_stall;
    char_word_t             char_data;
    logic                   num_valid;
    logic                   num_stall;
    num_word_t              num_data;

    // Model state
    scan_phase_t            scan_ph     = SCAN_DONE;
    bit                     is_negative = 1'b0;
    logic [VALUE_WIDTH-1:0] magnitude   = '0;
    bit                     clipped     = 1'b0;
    bit                     got_digit   = 1'b0;
    logic [RADIX_WIDTH-1:0] live_base   = '0;
    int unsigned            char_count  = 0;
    logic [RADIX_WIDTH-1:0] radix_copy  = RADIX_AUTO;
    bit                     char_ignored;

    num_word_t   number_q[$];
    plan_row_t   plan[$];
    int          flaw_count    = 0;
    int          cycle_count   = 0;
    int unsigned live_count    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_req      = 1'b0;

    ascii_integer_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_data   (char_data),
        .num_valid   (num_valid),
        .num_stall   (num_stall),
        .num_data    (num_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Local parser model
    // ------------------------------------------------------------------

    function automatic int unsigned glyph_value(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
        if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + 10;
        if (c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + 10;
        return 99;
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_HT && c <= CH_CR);
    endfunction

    function automatic bit radix_unusable(logic [RADIX_WIDTH-1:0] r);
        return r == RADIX_ONE || r > RADIX_MAX;
    endfunction

    // Shift one digit into the magnitude; once past the limit, keep eating
    // digits but leave the magnitude alone
    task automatic fold_digit(input int unsigned d);
        logic [VALUE_WIDTH-1:0] ceiling;
        logic [VALUE_WIDTH-1:0] cut;
        logic [VALUE_WIDTH-1:0] rem;
        logic [VALUE_WIDTH-1:0] b;
        b = VALUE_WIDTH'(live_base);
        ceiling = is_negative ? VALUE_MIN : VALUE_MAX;
        got_digit = 1'b1;
        if (clipped) return;
        cut = ceiling / b;
        rem = ceiling % b;
        if (magnitude > cut || (magnitude == cut && VALUE_WIDTH'(d) > rem))
            clipped = 1'b1;
        else
            magnitude = magnitude * b + VALUE_WIDTH'(d);
    endtask

    // Form the number word for the string and retire it
    task automatic close_number(input int unsigned end_pos, output num_word_t word);
        word = '0;
        if (got_digit)
        begin
            if (clipped)
                word.value = is_negative ? VALUE_MIN : VALUE_MAX;
            else
                word.value = is_negative ? -magnitude : magnitude;
            word.end_offset  = COUNT_WIDTH'(end_pos > COUNT_MAX ? COUNT_MAX : end_pos);
            word.converted   = 1'b1;
            word.range_error = clipped;
        end
        scan_ph = SCAN_DONE;
    endtask

    task automatic parse_char(input char_word_t w, output bit produced,
                              output num_word_t word);
        logic [7:0]  c;
        int unsigned d;
        scan_phase_t entry;
        bit          taken;
        bit          digit_step;
        c            = w.ch;
        produced     = 1'b0;
        word         = '0;
        taken        = 1'b0;
        digit_step   = 1'b0;
        char_ignored = 1'b0;

        // A start byte drops whatever string was open and latches the radix
        if (w.start_req)
        begin
            scan_ph     = SCAN_LEAD;
            is_negative = 1'b0;
            magnitude   = '0;
            clipped     = 1'b0;
            got_digit   = 1'b0;
            char_count  = 0;
            live_base   = radix_copy;
            if (radix_unusable(live_base))
            begin
                close_number(0, word);
                produced = 1'b1;
                return;
            end
        end
        if (scan_ph == SCAN_DONE)
        begin
            char_ignored = 1'b1;
            return;
        end

        entry = scan_ph;
        d     = glyph_value(c);

        if (entry == SCAN_LEAD)
        begin
            if (is_space(c))
                taken = 1'b1;
            else if (c == CH_MINUS)
            begin
                is_negative = 1'b1;
                scan_ph     = SCAN_SIGN;
                taken       = 1'b1;
            end
            else if (c == CH_PLUS)
            begin
                scan_ph = SCAN_SIGN;
                taken   = 1'b1;
            end
        end

        if (!taken && (entry == SCAN_LEAD || entry == SCAN_SIGN))
        begin
            // A leading zero may open a hex prefix or pick octal
            if (c == CH_ZERO && (live_base == RADIX_AUTO || live_base == RADIX_HEX))
            begin
                got_digit = 1'b1;
                scan_ph   = SCAN_ZERO;
            end
            else
            begin
                if (live_base == RADIX_AUTO) live_base = RADIX_DEC;
                if (d < live_base)
                begin
                    fold_digit(d);
                    scan_ph = SCAN_DIGITS;
                end
                else
                begin
                    close_number(char_count, word);
                    produced = 1'b1;
                end
            end
        end
        else if (entry == SCAN_ZERO)
        begin
            if (c == CH_LO_X || c == CH_UP_X)
            begin
                live_base = RADIX_HEX;
                scan_ph   = SCAN_HEXPFX;
            end
            else
            begin
                if (live_base == RADIX_AUTO) live_base = RADIX_OCT;
                scan_ph    = SCAN_DIGITS;
                digit_step = 1'b1;
            end
        end
        else if (entry == SCAN_DIGITS)
            digit_step = 1'b1;
        else if (entry == SCAN_HEXPFX)
        begin
            // No hex digit after the prefix: only the zero counts, end at the x
            if (d < 16)
            begin
                fold_digit(d);
                scan_ph = SCAN_DIGITS;
            end
            else
            begin
                close_number(char_count - 1, word);
                produced = 1'b1;
            end
        end

        if (digit_step)
        begin
            if (d < live_base)
                fold_digit(d);
            else
            begin
                close_number(char_count, word);
                produced = 1'b1;
            end
        end

        if (char_count < (1 << COUNT_WIDTH)) char_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one byte word, hold it until taken, then predict its outcome.
    // A pinned word replaces the prediction with the hand-typed number.
    task automatic send_char(input char_word_t w, input bit pinned,
                             input num_word_t pinned_word);
        int        gap;
        bit        produced;
        num_word_t word;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= w;
        @(posedge clk);
        while (char_stall) @(posedge clk);
        parse_char(w, produced, word);
        if (!char_ignored) live_count++;
        if (pinned) number_q.push_back(pinned_word);
        else if (produced) number_q.push_back(word);
    endtask

    // Drop valid, wait for every predicted number, then let the pipeline
    // run dry in case the last bytes were still being parsed
    task automatic settle();
        char_valid <= 1'b0;
        while (number_q.size() != 0) @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_WIDTH-1:0] v);
        radix_we    <= 1'b1;
        radix_wdata <= v;
        @(posedge clk);
        radix_we   <= 1'b0;
        radix_copy  = v;
    endtask

    function automatic logic [7:0] glyph_for(int unsigned d);
        if (d < 10) return CH_ZERO + 8'(d);
        if ($urandom_range(0, 1)) return CH_LO_A + 8'(d - 10);
        return CH_UP_A + 8'(d - 10);
    endfunction

    // Build one string, mostly well formed: blanks, sign, prefix, digits
    // (short, saturating, at the limit, or random 64-bit), terminator.
    // The rest is loose noise with a random start flag.
    task automatic send_random_string();
        char_word_t             burst[$];
        logic [7:0]             text[$];
        int unsigned            digs[$];
        char_word_t             cw;
        int unsigned            eff;
        int unsigned            n;
        int unsigned            r;
        logic [VALUE_WIDTH-1:0] val;
        logic [127:0]           reach;
        bit                     neg;
        neg = 1'b0;
        if ($urandom_range(0, 99) < 15)
        begin
            n = $urandom_range(1, 12);
            repeat (n)
            begin
                cw.ch        = 8'($urandom);
                cw.start_req = ($urandom_range(0, 7) == 0);
                burst.push_back(cw);
            end
        end
        else
        begin
            eff = (radix_copy == RADIX_AUTO || radix_unusable(radix_copy)) ? 10 : radix_copy;
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    r = $urandom_range(0, 5);
                    text.push_back(r == 5 ? CH_SPACE : CH_HT + 8'(r));
                end
            end
            r = $urandom_range(0, 3);
            if (r == 0)
            begin
                text.push_back(CH_MINUS);
                neg = 1'b1;
            end
            else if (r == 1)
                text.push_back(CH_PLUS);
            if ((radix_copy == RADIX_AUTO || radix_copy == RADIX_HEX)
                && $urandom_range(0, 2) == 0)
            begin
                text.push_back(CH_ZERO);
                text.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                eff = 16;
            end

            r = $urandom_range(0, 9);
            if (r <= 5)
            begin
                n = $urandom_range(1, 6);
                repeat (n) digs.push_back($urandom_range(0, eff - 1));
            end
            else if (r == 7)
            begin
                // Enough top digits to pass the limit, plus a few spare
                reach = 1;
                n     = 0;
                while (reach <= 128'h8000_0000_0000_0000)
                begin
                    reach = reach * eff;
                    n++;
                end
                n += $urandom_range(0, 3);
                repeat (n) digs.push_back(eff - 1);
            end
            else if (r >= 8)
            begin
                if (r == 8)
                begin
                    // Land on, just under or just over the limit
                    val = neg ? VALUE_MIN : VALUE_MAX;
                    val = val + $urandom_range(0, 2) - 1;
                end
                else
                    val = {$urandom, $urandom} >> $urandom_range(0, 63);
                do
                begin
                    digs.push_front(32'(val % eff));
                    val = val / eff;
                end
                while (val != 0);
            end
            foreach (digs[i]) text.push_back(glyph_for(digs[i]));

            r = $urandom_range(0, 9);
            if (r == 1)
                text.push_back(CH_NUL);
            else if (r == 2)
                text.push_back(8'($urandom));
            else if (r > 2)
                text.push_back(8'($urandom_range(0, 47)));
            if (text.size() == 0) text.push_back(CH_NUL);

            foreach (text[i])
            begin
                cw.ch        = text[i];
                cw.start_req = (i == 0);
                burst.push_back(cw);
            end
            // Stray bytes after the number are to be ignored
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 2);
                repeat (n)
                begin
                    cw.ch        = 8'($urandom);
                    cw.start_req = 1'b0;
                    burst.push_back(cw);
                end
            end
        end
        foreach (burst[i]) send_char(burst[i], 1'b0, '0);
    endtask

    function automatic logic [RADIX_WIDTH-1:0] pick_radix(int k);
        case (k)
            0:       return RADIX_AUTO;
            1:       return RADIX_HEX;
            2:       return RADIX_DEC;
            3:       return RADIX_BIN;
            4:       return RADIX_MAX;
            5:       return RADIX_OCT;
            6:       return RADIX_WIDTH'($urandom_range(3, 35));
            default:
                case ($urandom_range(0, 3))
                    0:       return RADIX_ONE;
                    1:       return RADIX_37;
                    2:       return RADIX_TOP;
                    default: return RADIX_WIDTH'($urandom_range(38, 62));
                endcase
        endcase
    endfunction

    function automatic plan_row_t cfg_row(logic [RADIX_WIDTH-1:0] v);
        plan_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.radix  = v;
        return row;
    endfunction

    function automatic plan_row_t char_row(logic [7:0] c, logic s);
        plan_row_t row;
        row                = '0;
        row.word.ch        = c;
        row.word.start_req = s;
        return row;
    endfunction

    function automatic plan_row_t pinned_row(logic [7:0] c, logic s,
                                             logic signed [VALUE_WIDTH-1:0] v,
                                             logic [COUNT_WIDTH-1:0] off,
                                             logic conv, logic rng);
        plan_row_t row;
        row                  = char_row(c, s);
        row.pinned           = 1'b1;
        row.want.value       = v;
        row.want.end_offset  = off;
        row.want.converted   = conv;
        row.want.range_error = rng;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: check every taken number word, stall at random, and
    // once hold off for a long stretch so the parser backs up
    // ------------------------------------------------------------------

    task automatic check_number(input num_word_t got);
        num_word_t want;
        if (number_q.size() == 0)
        begin
            flaw_count++;
            if (flaw_count <= REPORT_MAX)
                $display("unexpected number word: value %0d end %0d conv %0b range %0b",
                         $signed(got.value), got.end_offset, got.converted,
                         got.range_error);
            return;
        end
        want = number_q.pop_front();
        if (got.value !== want.value || got.end_offset !== want.end_offset
            || got.converted !== want.converted || got.range_error !== want.range_error)
        begin
            flaw_count++;
            if (flaw_count <= REPORT_MAX)
                $display("number mismatch: want %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                         $signed(want.value), want.end_offset, want.converted,
                         want.range_error, $signed(got.value), got.end_offset,
                         got.converted, got.range_error);
        end
    endtask

    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        num_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && num_valid && !num_stall) check_number(num_data);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_TICKS;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                num_stall <= 1'b1;
            end
            else
                num_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int unsigned            phase_base;
        logic [RADIX_WIDTH-1:0] rdx;

        rst_n       = 1'b0;
        radix_we    = 1'b0;
        radix_wdata = '0;
        char_valid  = 1'b0;
        char_data   = '0;

        // Directed table. Runs on the reset radix (auto-detect) first.
        // Negative sign and a hex prefix with no hex digit after it: only
        // the zero converts, and the offset points at the x
        plan.push_back(char_row(CH_SPACE, 1'b1));
        plan.push_back(char_row(CH_MINUS, 1'b0));
        plan.push_back(char_row(CH_ZERO, 1'b0));
        plan.push_back(char_row(CH_LO_X, 1'b0));
        plan.push_back(pinned_row(CH_LO_G, 1'b0, '0, COUNT_WIDTH'(3), 1'b1, 1'b0));
        // Nothing convertible: all-zero word; a byte after it is ignored
        plan.push_back(pinned_row(CH_LO_Z, 1'b1, '0, '0, 1'b0, 1'b0));
        plan.push_back(char_row(CH_ONES, 1'b0));
        // A radix of one is refused on the start byte
        plan.push_back(cfg_row(RADIX_ONE));
        plan.push_back(pinned_row(CH_SEVN, 1'b1, '0, '0, 1'b0, 1'b0));
        // Top radix: abandon a string mid-way, then saturate upwards
        plan.push_back(cfg_row(RADIX_MAX));
        plan.push_back(char_row(CH_ONE, 1'b1));
        plan.push_back(char_row(CH_PLUS, 1'b1));
        repeat (13) plan.push_back(char_row(CH_LO_Z, 1'b0));
        plan.push_back(pinned_row(CH_NUL, 1'b0, VALUE_MAX, COUNT_WIDTH'(14), 1'b1, 1'b1));

        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 20;
        recv_idle_pct = 71;
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                write_radix(plan[i].radix);
            end
            else
                send_char(plan[i].word, plan[i].pinned, plan[i].want);
        end

        // One signed string with a long run of leading zeros, back to back
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_radix(RADIX_DEC);
        send_char('{ch: CH_MINUS, start_req: 1'b1}, 1'b0, '0);
        repeat (LONG_RUN) send_char('{ch: CH_ZERO, start_req: 1'b0}, 1'b0, '0);
        send_char('{ch: CH_THRE, start_req: 1'b0}, 1'b0, '0);
        send_char('{ch: CH_LO_Q, start_req: 1'b0}, 1'b0, '0);

        // Random strings: sender idles lightly then heavily, then neither
        // side idles; each idling mode walks through eight radix settings
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 71 : 0;
            recv_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 20 : 0;
            for (int k = 0; k < 8; k++)
            begin
                settle();
                rdx = pick_radix(k);
                write_radix(rdx);
                if (mode == 2 && k == 0) hold_req = 1'b1;
                phase_base = live_count;
                while (live_count - phase_base < (radix_unusable(rdx) ? 10 : 55))
                    send_random_string();
            end
        end

        settle();
        repeat (2 * DRAIN_TICKS) @(posedge clk);
        if (flaw_count == 0 && number_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
